// ===== src/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

	// Default field widths.
	localparam int COORD_BITS_DEF  = 24;
	localparam int NORMAL_BITS_DEF = 16;

	// The normalized cross product magnitudes are kept to this many bits.
	localparam int A_BITS    = 30;
	// Sum of three squares of A_BITS values, and its integer square root.
	localparam int SUM_BITS  = 2 * A_BITS + 2;
	localparam int ROOT_BITS = A_BITS + 1;

endpackage

`default_nettype wire

// ===== src/tfn_tri_if.sv =====
// ----------------------------------------------------------------------------
// tfn_tri_if
// Channel carrying one triangle (three vertex positions) per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfn_tri_if #(
	parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] v0_x;
	logic signed [COORD_BITS-1:0] v0_y;
	logic signed [COORD_BITS-1:0] v0_z;
	logic signed [COORD_BITS-1:0] v1_x;
	logic signed [COORD_BITS-1:0] v1_y;
	logic signed [COORD_BITS-1:0] v1_z;
	logic signed [COORD_BITS-1:0] v2_x;
	logic signed [COORD_BITS-1:0] v2_y;
	logic signed [COORD_BITS-1:0] v2_z;

	modport source (
		output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		input  ready
	);
	modport sink (
		input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/tfn_nrm_if.sv =====
// ----------------------------------------------------------------------------
// tfn_nrm_if
// Channel carrying one unit face normal per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfn_nrm_if #(
	parameter int NORMAL_BITS = tfn_pkg::NORMAL_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [NORMAL_BITS-1:0] normal_x;
	logic signed [NORMAL_BITS-1:0] normal_y;
	logic signed [NORMAL_BITS-1:0] normal_z;
	logic                          degenerate;

	modport source (
		output valid, normal_x, normal_y, normal_z, degenerate,
		input  ready
	);
	modport sink (
		input  valid, normal_x, normal_y, normal_z, degenerate,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle: edge cross product, then normalization.
//
// Usage: tri_in takes one triangle per item (three vertices, signed Q12.12
// by default); nrm_out gives one item per triangle, in order: the unit normal
// in signed Q1.15, rounded to nearest and saturated to +-32767, and a
// degenerate flag that is set, with a zero normal, when the cross product is
// zero. Both channels use valid/ready; an item moves when both are high.
// The pipeline accepts one triangle every cycle while tri_in.ready is high.
// Most of its length is in the square root chain (one cell per root bit)
// and the division chain (one cell per normal bit).
// Reset clears all valid flags; no item is in flight afterwards. When the
// receiver stalls, the output register holds its item and one more item
// lands in a skid register; the pipeline then freezes and tri_in.ready
// drops until the skid register drains. tri_in.ready depends only on
// registered state.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal #(
	parameter int COORD_BITS  = tfn_pkg::COORD_BITS_DEF,
	parameter int NORMAL_BITS = tfn_pkg::NORMAL_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	tfn_tri_if.sink   tri_in,
	tfn_nrm_if.source nrm_out
);
	import tfn_pkg::*;

	localparam int E  = COORD_BITS + 1;
	localparam int P  = 2 * E;
	localparam int C  = 2 * E + 1;
	localparam int M  = 2 * E;
	localparam int W  = (M > A_BITS) ? M : A_BITS;
	localparam int K  = $clog2(W);
	localparam int NB = NORMAL_BITS;
	localparam int DW = A_BITS + NB + 1;
	localparam logic [NB-1:0] LIM = {1'b0, {(NB-1){1'b1}}};

	logic en;
	logic skid_full_q;
	logic out_valid_q;

	assign en           = !skid_full_q;
	assign tri_in.ready = en;

	// Edges.
	logic                v_s1;
	logic signed [E-1:0] e0_s1 [3];
	logic signed [E-1:0] e1_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= tri_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s1[0] <= E'(tri_in.v1_x) - E'(tri_in.v0_x);
			e0_s1[1] <= E'(tri_in.v1_y) - E'(tri_in.v0_y);
			e0_s1[2] <= E'(tri_in.v1_z) - E'(tri_in.v0_z);
			e1_s1[0] <= E'(tri_in.v2_x) - E'(tri_in.v0_x);
			e1_s1[1] <= E'(tri_in.v2_y) - E'(tri_in.v0_y);
			e1_s1[2] <= E'(tri_in.v2_z) - E'(tri_in.v0_z);
		end
	end

	// Cross product terms.
	logic                v_s2;
	logic signed [P-1:0] p_s2 [3];
	logic signed [P-1:0] q_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= P'(e0_s1[1]) * P'(e1_s1[2]);
			q_s2[0] <= P'(e0_s1[2]) * P'(e1_s1[1]);
			p_s2[1] <= P'(e0_s1[2]) * P'(e1_s1[0]);
			q_s2[1] <= P'(e0_s1[0]) * P'(e1_s1[2]);
			p_s2[2] <= P'(e0_s1[0]) * P'(e1_s1[1]);
			q_s2[2] <= P'(e0_s1[1]) * P'(e1_s1[0]);
		end
	end

	logic                v_s3;
	logic signed [C-1:0] cr_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cr_s3[i] <= C'(p_s2[i]) - C'(q_s2[i]);
			end
		end
	end

	// Magnitudes, then a chain of shift stages that brings the largest
	// magnitude's leading one to the top of the word.
	logic [C-1:0] abs_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_c[i] = cr_s3[i][C-1] ? C'(-cr_s3[i]) : C'(cr_s3[i]);
		end
	end

	logic         v_s4    [K+1];
	logic         zero_s4 [K+1];
	logic         neg_s4  [K+1][3];
	logic [W-1:0] mag_s4  [K+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4[0] <= 1'b0;
		else if (en) v_s4[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4[0] <= (cr_s3[0] == '0) && (cr_s3[1] == '0) && (cr_s3[2] == '0);
			for (int i = 0; i < 3; i++) begin
				neg_s4[0][i] <= cr_s3[i][C-1];
				mag_s4[0][i] <= W'(abs_c[i][M-1:0]);
			end
		end
	end

	for (genvar k = 0; k < K; k++) begin : g_nrm
		localparam int SH = 1 << (K - 1 - k);
		logic [W-1:0] orw;
		logic         up;

		always_comb begin
			orw = mag_s4[k][0] | mag_s4[k][1] | mag_s4[k][2];
			up  = orw[W-1 -: SH] == '0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s4[k+1] <= 1'b0;
			else if (en) v_s4[k+1] <= v_s4[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s4[k+1] <= zero_s4[k];
				for (int i = 0; i < 3; i++) begin
					neg_s4[k+1][i] <= neg_s4[k][i];
					mag_s4[k+1][i] <= up ? (mag_s4[k][i] << SH) : mag_s4[k][i];
				end
			end
		end
	end

	// Top A_BITS bits and their squares.
	logic                  v_s6;
	logic                  zero_s6;
	logic                  neg_s6 [3];
	logic [A_BITS-1:0]     a_s6   [3];
	logic [2*A_BITS-1:0]   sq_s6  [3];
	logic [A_BITS-1:0]     a_top  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_top[i] = mag_s4[K][i][W-1 -: A_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s4[K];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s6 <= zero_s4[K];
			for (int i = 0; i < 3; i++) begin
				neg_s6[i] <= neg_s4[K][i];
				a_s6[i]   <= a_top[i];
				sq_s6[i]  <= (2*A_BITS)'(a_top[i]) * (2*A_BITS)'(a_top[i]);
			end
		end
	end

	// Sum of squares, then the square root chain with the item carried along.
	logic                  v_s7    [ROOT_BITS+1];
	logic                  zero_s7 [ROOT_BITS+1];
	logic                  neg_s7  [ROOT_BITS+1][3];
	logic [A_BITS-1:0]     a_s7    [ROOT_BITS+1][3];
	logic [SUM_BITS-1:0]   sum_s7;
	logic [SUM_BITS-1:0]   rem_w   [ROOT_BITS];
	logic [ROOT_BITS-1:0]  root_w  [ROOT_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7[0] <= 1'b0;
		else if (en) v_s7[0] <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7     <= SUM_BITS'(sq_s6[0]) + SUM_BITS'(sq_s6[1]) + SUM_BITS'(sq_s6[2]);
			zero_s7[0] <= zero_s6;
			for (int i = 0; i < 3; i++) begin
				neg_s7[0][i] <= neg_s6[i];
				a_s7[0][i]   <= a_s6[i];
			end
		end
	end

	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
		logic [SUM_BITS-1:0]  rem_in;
		logic [ROOT_BITS-1:0] root_in;

		if (j == 0) begin : g_first
			assign rem_in  = sum_s7;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_w[j-1];
			assign root_in = root_w[j-1];
		end

		tfn_sqrt_cell #(
			.BIT (ROOT_BITS - 1 - j)
		) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (rem_in),
			.root_i (root_in),
			.rem_o  (rem_w[j]),
			.root_o (root_w[j])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s7[j+1] <= 1'b0;
			else if (en) v_s7[j+1] <= v_s7[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s7[j+1] <= zero_s7[j];
				for (int i = 0; i < 3; i++) begin
					neg_s7[j+1][i] <= neg_s7[j][i];
					a_s7[j+1][i]   <= a_s7[j][i];
				end
			end
		end
	end

	// Rounded dividends, then the division chains, one per component.
	logic [ROOT_BITS-1:0] len;
	logic                 v_s8    [NB+1];
	logic                 zero_s8 [NB+1];
	logic                 neg_s8  [NB+1][3];
	logic [ROOT_BITS-1:0] len_s8  [NB+1];
	logic [DW-1:0]        dvd_s8  [3];
	logic [DW-1:0]        drem_w  [NB][3];
	logic [NB-1:0]        dquo_w  [NB][3];

	assign len = root_w[ROOT_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8[0] <= 1'b0;
		else if (en) v_s8[0] <= v_s7[ROOT_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s8[0] <= zero_s7[ROOT_BITS];
			len_s8[0]  <= len;
			for (int i = 0; i < 3; i++) begin
				neg_s8[0][i] <= neg_s7[ROOT_BITS][i];
				dvd_s8[i]    <= (DW'(a_s7[ROOT_BITS][i]) << (NB - 1)) + DW'(len >> 1);
			end
		end
	end

	for (genvar j = 0; j < NB; j++) begin : g_div
		for (genvar i = 0; i < 3; i++) begin : g_comp
			logic [DW-1:0] rem_in;
			logic [NB-1:0] quo_in;

			if (j == 0) begin : g_first
				assign rem_in = dvd_s8[i];
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = drem_w[j-1][i];
				assign quo_in = dquo_w[j-1][i];
			end

			tfn_div_cell #(
				.DW  (DW),
				.QW  (NB),
				.BIT (NB - 1 - j)
			) u_cell (
				.clk   (clk),
				.en    (en),
				.rem_i (rem_in),
				.quo_i (quo_in),
				.den_i (len_s8[j]),
				.rem_o (drem_w[j][i]),
				.quo_o (dquo_w[j][i])
			);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s8[j+1] <= 1'b0;
			else if (en) v_s8[j+1] <= v_s8[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s8[j+1] <= zero_s8[j];
				len_s8[j+1]  <= len_s8[j];
				for (int i = 0; i < 3; i++) begin
					neg_s8[j+1][i] <= neg_s8[j][i];
				end
			end
		end
	end

	// Saturate, apply sign, force zero for a degenerate triangle.
	logic          v_s9;
	logic          deg_s9;
	logic [NB-1:0] n_s9  [3];
	logic [NB-1:0] sat   [3];
	logic [NB-1:0] fin   [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sat[i] = (dquo_w[NB-1][i] > LIM) ? LIM : dquo_w[NB-1][i];
			if (zero_s8[NB]) fin[i] = '0;
			else if (neg_s8[NB][i]) fin[i] = -sat[i];
			else fin[i] = sat[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8[NB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s9 <= zero_s8[NB];
			for (int i = 0; i < 3; i++) begin
				n_s9[i] <= fin[i];
			end
		end
	end

	// Output register with a skid register behind it.
	logic          ld_pipe;
	logic          out_deg_q;
	logic          skid_deg_q;
	logic [NB-1:0] out_n_q  [3];
	logic [NB-1:0] skid_n_q [3];

	assign ld_pipe = v_s9 && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_valid_q || nrm_out.ready) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= ld_pipe;
			end
		end else if (ld_pipe) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || nrm_out.ready) begin
			if (skid_full_q) begin
				out_deg_q <= skid_deg_q;
				out_n_q   <= skid_n_q;
			end else begin
				out_deg_q <= deg_s9;
				out_n_q   <= n_s9;
			end
		end else if (ld_pipe) begin
			skid_deg_q <= deg_s9;
			skid_n_q   <= n_s9;
		end
	end

	assign nrm_out.valid      = out_valid_q;
	assign nrm_out.normal_x   = out_n_q[0];
	assign nrm_out.normal_y   = out_n_q[1];
	assign nrm_out.normal_z   = out_n_q[2];
	assign nrm_out.degenerate = out_deg_q;

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_valid_q && !nrm_out.ready))
		else $error("skid register filled without a stalled output");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_deg_q) |->
			(out_n_q[0] == '0 && out_n_q[1] == '0 && out_n_q[2] == '0))
		else $error("degenerate item with a nonzero normal");

	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_n_q[0] != ~LIM && out_n_q[1] != ~LIM && out_n_q[2] != ~LIM))
		else $error("normal component outside the saturated range");
`endif
endmodule

`default_nettype wire

// ===== src/tfn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tfn_sqrt_cell
// One step of the digit-by-digit square root: decides root bit BIT.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_sqrt_cell #(
	parameter int BIT = 0
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [tfn_pkg::SUM_BITS-1:0]  rem_i,
	input  wire logic [tfn_pkg::ROOT_BITS-1:0] root_i,
	output logic      [tfn_pkg::SUM_BITS-1:0]  rem_o,
	output logic      [tfn_pkg::ROOT_BITS-1:0] root_o
);
	import tfn_pkg::*;

	localparam int TW = SUM_BITS + 2;

	logic [TW-1:0] trial;
	logic          take;

	// (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
	always_comb begin
		trial = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
		take  = TW'(rem_i) >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= take ? SUM_BITS'(TW'(rem_i) - trial) : rem_i;
			root_o <= take ? (root_i | (ROOT_BITS'(1) << BIT)) : root_i;
		end
	end
endmodule

`default_nettype wire

// ===== src/tfn_div_cell.sv =====
// ----------------------------------------------------------------------------
// tfn_div_cell
// One step of restoring division: decides quotient bit BIT.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_div_cell #(
	parameter int DW  = 47,
	parameter int QW  = 16,
	parameter int BIT = 0
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [DW-1:0]                  rem_i,
	input  wire logic [QW-1:0]                  quo_i,
	input  wire logic [tfn_pkg::ROOT_BITS-1:0] den_i,
	output logic      [DW-1:0]                  rem_o,
	output logic      [QW-1:0]                  quo_o
);
	import tfn_pkg::*;

	logic [DW-1:0] shifted;
	logic          take;

	always_comb begin
		shifted = DW'(den_i) << BIT;
		take    = rem_i >= shifted;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= take ? rem_i - shifted : rem_i;
			quo_o <= take ? (quo_i | (QW'(1) << BIT)) : quo_i;
		end
	end
endmodule

`default_nettype wire
